// ----- hw/rtl/dss_pkg.sv -----
// Package for the disk seek scheduler: constants, register indexes and the
// layout of one stored request. Used by disk_seek_scheduler; depends on nothing.
package dss_pkg;

    localparam int MAX_REQUESTS_DEF = 32;

    localparam int TIME_W  = 16;
    localparam int TRACK_W = 12;
    localparam int PROC_W  = 8;
    localparam int NUM_W   = 6;
    localparam int MOVE_W  = 17;

    localparam logic [MOVE_W-1:0] MOVE_MAX = 17'd131071;

    localparam int REG_IDX_W = 1;
    localparam int REG_DATA_W = TRACK_W;

    localparam logic [REG_IDX_W-1:0] REG_MODE  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_START = 1'd1;

    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_SSTF = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  arrival;
        logic [TRACK_W-1:0] track;
        logic [PROC_W-1:0]  process;
    } entry_t;

endpackage

// ----- hw/rtl/disk_seek_scheduler.sv -----
// Top level of the disk seek scheduler: request store, minimum search and
// result output. Depends on dss_pkg.
//
// Usage: requests are loaded one per cycle on start while busy is low; each
// carries arrival_time, target_track, owner_process and last_request. Entries
// beyond MAX_REQUESTS are dropped, but a last_request mark still ends the batch.
// The item with last_request set raises busy and the block emits the service
// order, one result per served request, each marked by strobe for one cycle.
// The configuration port (wr_en, wr_index, wr_data) sets the mode, 0 for first
// come first served and 1 for shortest seek first, and the start cylinder; both
// are sampled when the final request is taken.
// For each result the search reads the request memory once per entry, through
// its single read port, and then passes through a drain state and an emit
// state. Busy falls as the last result shows. The receiver cannot stall, so
// results are simply presented, each marked only by its strobe. Reset clears the
// configuration to shortest seek first from cylinder 0, empties the store and
// returns the block to idle at once.
module disk_seek_scheduler #(
    parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dss_pkg::TIME_W-1:0]      arrival_time,
    input  logic [dss_pkg::TRACK_W-1:0]     target_track,
    input  logic [dss_pkg::PROC_W-1:0]      owner_process,
    input  logic                            last_request,
    input  logic                            wr_en,
    input  logic [dss_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [dss_pkg::REG_DATA_W-1:0]  wr_data,
    output logic                            strobe,
    output logic [dss_pkg::NUM_W-1:0]       request_number,
    output logic [dss_pkg::PROC_W-1:0]      served_process,
    output logic [dss_pkg::TRACK_W-1:0]     served_track,
    output logic [dss_pkg::TRACK_W-1:0]     seek_distance,
    output logic [dss_pkg::MOVE_W-1:0]      head_travel,
    output logic                            last_served
);

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        EMIT
    } state_t;

    state_t state_reg;

    dss_pkg::entry_t mem [MAX_REQUESTS];
    dss_pkg::entry_t rd_data_reg;

    logic                          mode_cfg_reg;
    logic [dss_pkg::TRACK_W-1:0]   start_cfg_reg;
    logic                          mode_run_reg;
    logic [CNT_W-1:0]              loaded_count_reg;
    logic [CNT_W-1:0]              emitted_reg;
    logic [MAX_REQUESTS-1:0]       served_reg;
    logic [dss_pkg::TRACK_W-1:0]   head_reg;
    logic [dss_pkg::MOVE_W-1:0]    sum_reg;
    logic [IDX_W-1:0]              scan_addr_reg;
    logic                          data_valid_reg;
    logic [IDX_W-1:0]              data_idx_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [dss_pkg::TRACK_W-1:0]   best_dist_reg;
    logic [dss_pkg::TIME_W-1:0]    best_arrival_reg;
    logic [dss_pkg::TRACK_W-1:0]   best_track_reg;
    logic [dss_pkg::PROC_W-1:0]    best_process_reg;

    logic                          strobe_reg;
    logic [dss_pkg::NUM_W-1:0]     number_reg;
    logic [dss_pkg::PROC_W-1:0]    process_out_reg;
    logic [dss_pkg::TRACK_W-1:0]   track_out_reg;
    logic [dss_pkg::TRACK_W-1:0]   dist_out_reg;
    logic                          last_out_reg;

    logic                          accept;
    logic                          store_ok;
    logic [dss_pkg::TRACK_W-1:0]   cand_dist;
    logic                          better;
    logic                          take;
    logic                          scan_last;
    logic                          emit_last;
    logic [dss_pkg::MOVE_W:0]      sum_next;
    logic [dss_pkg::MOVE_W-1:0]    sum_sat;

    assign busy     = (state_reg != IDLE);
    assign accept   = start && !busy;
    assign store_ok = (loaded_count_reg < CNT_W'(MAX_REQUESTS));

    assign scan_last = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == loaded_count_reg);
    assign emit_last = ((emitted_reg + CNT_W'(1)) == loaded_count_reg);

    always_comb
    begin
        if (head_reg > rd_data_reg.track)
        begin
            cand_dist = head_reg - rd_data_reg.track;
        end
        else
        begin
            cand_dist = rd_data_reg.track - head_reg;
        end
        if (mode_run_reg == dss_pkg::MODE_SSTF)
        begin
            better = (cand_dist < best_dist_reg) ||
                     ((cand_dist == best_dist_reg) &&
                      (rd_data_reg.arrival < best_arrival_reg));
        end
        else
        begin
            better = (rd_data_reg.arrival < best_arrival_reg);
        end
        take = data_valid_reg && !served_reg[data_idx_reg] && (!found_reg || better);
        sum_next = {1'b0, sum_reg} + (dss_pkg::MOVE_W + 1)'(best_dist_reg);
        if (sum_next > {1'b0, dss_pkg::MOVE_MAX})
        begin
            sum_sat = dss_pkg::MOVE_MAX;
        end
        else
        begin
            sum_sat = sum_next[dss_pkg::MOVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            mem[loaded_count_reg[IDX_W-1:0]] <= '{arrival: arrival_time,
                                                  track:   target_track,
                                                  process: owner_process};
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            mode_cfg_reg     <= dss_pkg::MODE_SSTF;
            start_cfg_reg    <= '0;
            mode_run_reg     <= dss_pkg::MODE_SSTF;
            loaded_count_reg <= '0;
            emitted_reg      <= '0;
            served_reg       <= '0;
            head_reg         <= '0;
            sum_reg          <= '0;
            scan_addr_reg    <= '0;
            data_valid_reg   <= 1'b0;
            data_idx_reg     <= '0;
            found_reg        <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;

            if (wr_en)
            begin
                unique case (wr_index)
                    dss_pkg::REG_MODE:  mode_cfg_reg  <= wr_data[0];
                    dss_pkg::REG_START: start_cfg_reg <= wr_data;
                endcase
            end

            data_valid_reg <= (state_reg == SCAN);
            data_idx_reg   <= scan_addr_reg;

            if (take)
            begin
                found_reg        <= 1'b1;
                best_idx_reg     <= data_idx_reg;
                best_dist_reg    <= cand_dist;
                best_arrival_reg <= rd_data_reg.arrival;
                best_track_reg   <= rd_data_reg.track;
                best_process_reg <= rd_data_reg.process;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (store_ok)
                        begin
                            served_reg[loaded_count_reg[IDX_W-1:0]] <= 1'b0;
                            loaded_count_reg <= loaded_count_reg + CNT_W'(1);
                        end
                        if (last_request)
                        begin
                            state_reg     <= SCAN;
                            mode_run_reg  <= mode_cfg_reg;
                            head_reg      <= start_cfg_reg;
                            sum_reg       <= '0;
                            emitted_reg   <= '0;
                            scan_addr_reg <= '0;
                            found_reg     <= 1'b0;
                        end
                    end
                end
                SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= DRAIN;
                    end
                    else
                    begin
                        scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                    end
                end
                DRAIN:
                begin
                    state_reg <= EMIT;
                end
                EMIT:
                begin
                    strobe_reg      <= 1'b1;
                    number_reg      <= dss_pkg::NUM_W'({1'b0, best_idx_reg} + (IDX_W + 1)'(1));
                    process_out_reg <= best_process_reg;
                    track_out_reg   <= best_track_reg;
                    dist_out_reg    <= best_dist_reg;
                    last_out_reg    <= emit_last;
                    served_reg[best_idx_reg] <= 1'b1;
                    head_reg        <= best_track_reg;
                    sum_reg         <= sum_sat;
                    emitted_reg     <= emitted_reg + CNT_W'(1);
                    found_reg       <= 1'b0;
                    scan_addr_reg   <= '0;
                    if (emit_last)
                    begin
                        state_reg        <= IDLE;
                        loaded_count_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= SCAN;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign strobe         = strobe_reg;
    assign request_number = number_reg;
    assign served_process = process_out_reg;
    assign served_track   = track_out_reg;
    assign seek_distance  = dist_out_reg;
    assign head_travel    = sum_reg;
    assign last_served    = last_out_reg;

    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == EMIT))
        else $error("result strobe without a preceding emit cycle");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_served) |-> !busy)
        else $error("block still busy after the final result of a batch");

    a_total_covers_seek: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ({5'd0, seek_distance} <= head_travel))
        else $error("running movement smaller than the current seek");

    a_data_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid_reg |-> (state_reg == SCAN || state_reg == DRAIN))
        else $error("memory read data outside the search");

    a_final_starts_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_request) |=> busy)
        else $error("final request did not start scheduling");

endmodule
